@@ sv/bpdc_pkg.sv @@
// Package for the button press duration classifier.
// Holds the shared types, register map codes and reset constants.
// No dependencies.
package bpdc_pkg;

  localparam int unsigned CntW    = 16;
  localparam int unsigned CfgDets = 3;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [CntW-1:0] HOLD_MAX = 16'hFFFF;

  // Standard window lengths in 1 ms ticks
  localparam logic [CntW-1:0] TICKS_200MS = 16'd200;
  localparam logic [CntW-1:0] TICKS_1S    = 16'd1000;
  localparam logic [CntW-1:0] TICKS_3S    = 16'd3000;
  localparam logic [CntW-1:0] TICKS_10S   = 16'd10000;

  localparam logic [CntW-1:0] RST_MIN [CfgDets] = '{
    TICKS_200MS, TICKS_3S, TICKS_3S};
  localparam logic [CntW-1:0] RST_MAX [CfgDets] = '{
    TICKS_1S, TICKS_10S, TICKS_10S};
  localparam logic [CfgDets-1:0] RST_REL_MODE = 3'b001;
  localparam logic [CntW-1:0]    RST_COOLDOWN = TICKS_200MS;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_E0_MIN   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_E0_MAX   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_E1_MIN   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_E1_MAX   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_E2_MIN   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_E2_MAX   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_REL_MODE = 3'd6;
  localparam logic [RegIdxW-1:0] REG_COOLDOWN = 3'd7;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic tick;     // advance one 1 ms tick
    logic pressed;  // button level for this tick
    logic clr;      // read-and-clear of this detector's flag
  } det_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] min_ticks;
    logic [CntW-1:0] max_ticks;
    logic            rel_mode;
    logic [CntW-1:0] cooldown;
  } det_cfg_t;

endpackage

@@ sv/bpdc_det.sv @@
// One press-duration detector: hold counter, cooldown counter and flag.
// Depends on bpdc_pkg for det_ctrl_t, det_cfg_t and counter widths.
module bpdc_det (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bpdc_pkg::det_ctrl_t  ctrl,
  input  bpdc_pkg::det_cfg_t   cfg,
  output logic                 flag_o,
  output logic                 flag_nxt_o
);

  logic [bpdc_pkg::CntW-1:0] hold_r, hold_nxt;
  logic [bpdc_pkg::CntW-1:0] cool_r, cool_nxt;
  logic                      flag_r, flag_nxt;
  logic [bpdc_pkg::CntW-1:0] hold_inc;
  logic                      fire;

  always_comb begin
    hold_nxt = hold_r;
    cool_nxt = cool_r;
    flag_nxt = flag_r;
    hold_inc = hold_r;
    fire     = 1'b0;
    if (ctrl.tick) begin
      if (cool_r != '0) begin
        // frozen while cooling down; count only released ticks
        if (!ctrl.pressed) begin
          cool_nxt = cool_r - 1'b1;
        end
      end else begin
        flag_nxt = 1'b0;
        if (ctrl.pressed && hold_r != bpdc_pkg::HOLD_MAX) begin
          hold_inc = hold_r + 1'b1;
        end
        if (cfg.rel_mode) begin
          fire = !ctrl.pressed && hold_inc >= cfg.min_ticks && hold_inc <= cfg.max_ticks;
        end else begin
          fire = hold_inc >= cfg.min_ticks;
        end
        if (fire) begin
          cool_nxt = cfg.cooldown;
          flag_nxt = 1'b1;
          hold_nxt = '0;
        end else if (!ctrl.pressed) begin
          hold_nxt = '0;
        end else begin
          hold_nxt = hold_inc;
        end
      end
    end else if (ctrl.clr) begin
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= '0;
      cool_r <= '0;
      flag_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
      cool_r <= cool_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign flag_o     = flag_r;
  assign flag_nxt_o = flag_nxt;

endmodule

@@ sv/button_press_duration_classifier.sv @@
// A result is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; the output register lets a new beat in
// whenever it is empty or being drained in the same cycle.
// Reset (synchronous, rst_n low): counters and flags clear, registers take
// their default windows, the output register empties.
module button_press_duration_classifier #(
  parameter int unsigned NUM_DETECTORS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic                          in_pressed,
  input  logic [1:0]                    in_entry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_read_flag,
  output logic [2:0]                    out_flag_bits,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpdc_pkg::AddrW-1:0]    paddr,
  input  logic [bpdc_pkg::DataW-1:0]    pwdata,
  output logic [bpdc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CW = bpdc_pkg::CntW;

  // Configuration registers
  logic [CW-1:0]                min_r [bpdc_pkg::CfgDets];
  logic [CW-1:0]                max_r [bpdc_pkg::CfgDets];
  logic [bpdc_pkg::CfgDets-1:0] rel_r;
  logic [CW-1:0]                cool_r;

  logic                         wr_en;
  logic [bpdc_pkg::RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[bpdc_pkg::AddrW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bpdc_pkg::CfgDets; i++) begin
        min_r[i] <= bpdc_pkg::RST_MIN[i];
        max_r[i] <= bpdc_pkg::RST_MAX[i];
      end
      rel_r  <= bpdc_pkg::RST_REL_MODE;
      cool_r <= bpdc_pkg::RST_COOLDOWN;
    end else if (wr_en) begin
      unique case (reg_idx)
        bpdc_pkg::REG_E0_MIN:   min_r[0] <= pwdata[CW-1:0];
        bpdc_pkg::REG_E0_MAX:   max_r[0] <= pwdata[CW-1:0];
        bpdc_pkg::REG_E1_MIN:   min_r[1] <= pwdata[CW-1:0];
        bpdc_pkg::REG_E1_MAX:   max_r[1] <= pwdata[CW-1:0];
        bpdc_pkg::REG_E2_MIN:   min_r[2] <= pwdata[CW-1:0];
        bpdc_pkg::REG_E2_MAX:   max_r[2] <= pwdata[CW-1:0];
        bpdc_pkg::REG_REL_MODE: rel_r    <= pwdata[bpdc_pkg::CfgDets-1:0];
        bpdc_pkg::REG_COOLDOWN: cool_r   <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bpdc_pkg::REG_E0_MIN:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, min_r[0]};
      bpdc_pkg::REG_E0_MAX:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, max_r[0]};
      bpdc_pkg::REG_E1_MIN:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, min_r[1]};
      bpdc_pkg::REG_E1_MAX:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, max_r[1]};
      bpdc_pkg::REG_E2_MIN:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, min_r[2]};
      bpdc_pkg::REG_E2_MAX:   prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, max_r[2]};
      bpdc_pkg::REG_REL_MODE:
        prdata = {{(bpdc_pkg::DataW-bpdc_pkg::CfgDets){1'b0}}, rel_r};
      bpdc_pkg::REG_COOLDOWN: prdata = {{(bpdc_pkg::DataW-CW){1'b0}}, cool_r};
      default: ;
    endcase
  end

  // Handshake and output register
  logic       out_valid_r, out_valid_nxt;
  logic       rd_flag_r, rd_flag_nxt;
  logic [2:0] flag_bits_r, flag_bits_nxt;
  logic       in_acc;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  logic [NUM_DETECTORS-1:0] flag_cur;
  logic [NUM_DETECTORS-1:0] flag_nxt;

  for (genvar g = 0; g < NUM_DETECTORS; g++) begin : g_det
    bpdc_pkg::det_ctrl_t ctrl;
    bpdc_pkg::det_cfg_t  cfg;

    assign ctrl.tick    = in_acc && (in_operation == bpdc_pkg::OP_TICK);
    assign ctrl.pressed = in_pressed;
    assign ctrl.clr     = in_acc && (in_operation == bpdc_pkg::OP_READ)
                          && (int'(in_entry) == g);

    if (g < bpdc_pkg::CfgDets) begin : g_cfg
      assign cfg.min_ticks = min_r[g];
      assign cfg.max_ticks = max_r[g];
      assign cfg.rel_mode  = rel_r[g];
    end else begin : g_fixed
      // extra detectors keep the last detector's default window
      assign cfg.min_ticks = bpdc_pkg::RST_MIN[bpdc_pkg::CfgDets-1];
      assign cfg.max_ticks = bpdc_pkg::RST_MAX[bpdc_pkg::CfgDets-1];
      assign cfg.rel_mode  = 1'b0;
    end
    assign cfg.cooldown = cool_r;

    bpdc_det u_det (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cfg        (cfg),
      .flag_o     (flag_cur[g]),
      .flag_nxt_o (flag_nxt[g])
    );
  end

  always_comb begin
    rd_flag_nxt   = rd_flag_r;
    flag_bits_nxt = flag_bits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
      rd_flag_nxt   = 1'b0;
      if (in_operation == bpdc_pkg::OP_READ) begin
        for (int i = 0; i < NUM_DETECTORS; i++) begin
          if (int'(in_entry) == i) begin
            rd_flag_nxt = flag_cur[i];
          end
        end
      end
      flag_bits_nxt = '0;
      for (int i = 0; i < NUM_DETECTORS && i < 3; i++) begin
        flag_bits_nxt[i] = flag_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_flag_r   <= rd_flag_nxt;
    flag_bits_r <= flag_bits_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_flag = rd_flag_r;
  assign out_flag_bits = flag_bits_r;

endmodule

@@ sv/bpdc_chk.sv @@
// Port-level checker for the button press duration classifier.
// Depends on bpdc_pkg for operation codes; bound to the top level below.
module bpdc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic [1:0] in_entry,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_read_flag,
  input logic [2:0] out_flag_bits
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_flag)
      && $stable(out_flag_bits))
    else $error("result beat changed while stalled");

  // every accepted beat shows a result in the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid)
    else $error("accepted beat produced no result");

  // a tick never reports a read flag
  a_tick_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == bpdc_pkg::OP_TICK |=> !out_read_flag)
    else $error("read_flag set on a tick");

  // a read leaves the chosen detector's flag clear
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation == bpdc_pkg::OP_READ |=>
      !(($past(in_entry) == 2'd0 && out_flag_bits[0])
        || ($past(in_entry) == 2'd1 && out_flag_bits[1])
        || ($past(in_entry) == 2'd2 && out_flag_bits[2])))
    else $error("flag still set after read");

endmodule

bind button_press_duration_classifier bpdc_chk u_bpdc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_operation  (in_operation),
  .in_entry      (in_entry),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_read_flag (out_read_flag),
  .out_flag_bits (out_flag_bits)
);
